[sv/mls_pkg.sv]
// ----------------------------------------------------------------------------
// mls_pkg
// Shared widths and the stage payload type of the minbee limited slope pipeline.
// ----------------------------------------------------------------------------
package mls_pkg;

  localparam int DataW  = 32;
  localparam int FracW  = 16;
  localparam int CoefW  = FracW + 2;
  localparam int DiffW  = DataW + 1;
  localparam int ProdW  = DiffW + CoefW + 1;
  localparam int SumW   = ProdW + 1;
  localparam int DeltaW = DataW + 2;
  localparam int DvsW   = DiffW + 1;
  localparam int RemW   = DvsW + 1;
  localparam int QuoW   = 31;
  localparam int PhiW   = 30;
  localparam int StepN  = QuoW;

  typedef struct packed {
    logic [RemW-1:0]          rem;
    logic [DvsW-1:0]          dvs;
    logic [QuoW-1:0]          quo;
    logic signed [DeltaW-1:0] delta;
    logic                     half;
    logic                     nz;
  } div_t;

endpackage

[sv/mls_front.sv]
// ----------------------------------------------------------------------------
// mls_front
// Differences, weighted products and rounded slope; seeds the divider.
// ----------------------------------------------------------------------------
module mls_front import mls_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [DataW-1:0] left_value_i,
  input  logic signed [DataW-1:0] centre_value_i,
  input  logic signed [DataW-1:0] right_value_i,
  input  logic [CoefW-1:0]        coef_l_i,
  input  logic [CoefW-1:0]        coef_r_i,
  output logic                    valid_o,
  output div_t                    div_o
);

  logic                    v1_q, v2_q, v3_q;
  logic signed [DiffW-1:0] dl_q, dr_q;
  logic [CoefW-1:0]        cl_q, cr_q;
  logic signed [ProdW-1:0] pl_q, pr_q;
  logic [DvsW-1:0]         dvs_q;
  logic [DiffW-1:0]        num_q;
  logic                    half_q, nz_q;
  div_t                    div_q;

  logic signed [DiffW-1:0] dl_d, dr_d;
  logic [DiffW-1:0]        adl, adr;
  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  sum_sh;

  assign dl_d = DiffW'(centre_value_i) - DiffW'(left_value_i);
  assign dr_d = DiffW'(right_value_i) - DiffW'(centre_value_i);
  assign adl  = dl_q[DiffW-1] ? DiffW'(-dl_q) : DiffW'(dl_q);
  assign adr  = dr_q[DiffW-1] ? DiffW'(-dr_q) : DiffW'(dr_q);
  assign sum  = SumW'(pl_q) + SumW'(pr_q) + SumW'(signed'({1'b0, 16'h0}) + (1 <<< FracW));
  assign sum_sh = sum >>> (FracW + 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dl_q   <= dl_d;
      dr_q   <= dr_d;
      cl_q   <= coef_l_i;
      cr_q   <= coef_r_i;
      pl_q   <= signed'({1'b0, cl_q}) * dl_q;
      pr_q   <= signed'({1'b0, cr_q}) * dr_q;
      nz_q   <= (dl_q != '0) && (dr_q != '0) && (dl_q[DiffW-1] == dr_q[DiffW-1]);
      half_q <= adl < adr;
      if (adl < adr) begin
        num_q <= adl;
        dvs_q <= DvsW'(adr);
      end else begin
        num_q <= adr;
        dvs_q <= DvsW'(adl) + DvsW'(adr);
      end
      div_q.rem   <= RemW'(num_q);
      div_q.dvs   <= dvs_q;
      div_q.quo   <= '0;
      div_q.delta <= sum_sh[DeltaW-1:0];
      div_q.half  <= half_q;
      div_q.nz    <= nz_q;
    end
  end

  assign valid_o = v3_q;
  assign div_o   = div_q;

endmodule

[sv/mls_div_step.sv]
// ----------------------------------------------------------------------------
// mls_div_step
// One registered restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module mls_div_step import mls_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t div_i,
  output logic valid_o,
  output div_t div_o
);

  logic            v_q;
  div_t            div_q;
  div_t            div_d;
  logic [RemW-1:0] r2;
  logic            ge;

  assign r2 = {div_i.rem[RemW-2:0], 1'b0};
  assign ge = r2 >= RemW'(div_i.dvs);

  always_comb begin
    div_d     = div_i;
    div_d.rem = ge ? (r2 - RemW'(div_i.dvs)) : r2;
    div_d.quo = {div_i.quo[QuoW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = v_q;
  assign div_o   = div_q;

endmodule

[sv/mls_back.sv]
// ----------------------------------------------------------------------------
// mls_back
// Limiter times slope in two partial products, rounding and saturation.
// ----------------------------------------------------------------------------
module mls_back import mls_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  div_t                    div_i,
  output logic                    valid_o,
  output logic signed [DataW-1:0] slope_o
);

  localparam int LoW  = 16;
  localparam int HiW  = QuoW - LoW;
  localparam int AccW = DeltaW + QuoW + 1;
  localparam int MW   = AccW - PhiW;

  logic                  v1_q, v2_q;
  logic [DeltaW-1:0]     mag;
  logic [QuoW-1:0]       phi;
  logic [DeltaW+LoW-1:0] plo_q;
  logic [DeltaW+HiW-1:0] phi_hi_q;
  logic                  neg_q;
  logic [AccW-1:0]       acc;
  logic [MW-1:0]         m;
  logic signed [DataW-1:0] res_q, res_d;

  assign mag = div_i.delta[DeltaW-1] ? DeltaW'(-div_i.delta) : DeltaW'(div_i.delta);
  assign phi = !div_i.nz ? '0 : (div_i.half ? (div_i.quo >> 1) : div_i.quo);
  assign acc = (AccW'(phi_hi_q) << LoW) + AccW'(plo_q) + (AccW'(1) << (PhiW - 1));
  assign m   = acc[AccW-1:PhiW];

  always_comb begin
    if (neg_q) begin
      if (m > MW'(1) << (DataW - 1)) res_d = {1'b1, {(DataW-1){1'b0}}};
      else res_d = DataW'(-signed'(m));
    end else begin
      if (m > (MW'(1) << (DataW - 1)) - MW'(1)) res_d = {1'b0, {(DataW-1){1'b1}}};
      else res_d = DataW'(m);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q    <= (DeltaW+LoW)'(mag) * (DeltaW+LoW)'(phi[LoW-1:0]);
      phi_hi_q <= (DeltaW+HiW)'(mag) * (DeltaW+HiW)'(phi[QuoW-1:LoW]);
      neg_q    <= div_i.delta[DeltaW-1];
      res_q    <= res_d;
    end
  end

  assign valid_o = v2_q;
  assign slope_o = res_q;

endmodule

[sv/minbee_limited_slope.sv]
// ----------------------------------------------------------------------------
// minbee_limited_slope
// Minbee-limited MUSCL slope of one cell from its three-point stencil.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i with left/centre/right values; a transaction
//   completes when in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o with limited_slope_o; a transaction completes
//   when out_valid_o is high and out_stall_i is low.
// Weight: cfg_we_i writes cfg_wdata_i (signed Q1.16), clamped to -1..1.
// Throughput: one transaction per cycle while not stalled; the pipeline holds 36 stages
//   (three front, one per quotient bit of the 31-step divider, two for
//   the product), then an output register.
// Stall: a skid register catches the one result in flight; in_stall_o is
//   registered and the whole pipeline holds while the skid is full.
// Reset: clears all valid bits and sets the weight to zero.
// ----------------------------------------------------------------------------
module minbee_limited_slope import mls_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic signed [CoefW-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [DataW-1:0] left_value_i,
  input  logic signed [DataW-1:0] centre_value_i,
  input  logic signed [DataW-1:0] right_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] limited_slope_o
);

  localparam logic signed [CoefW-1:0] One = CoefW'(1 <<< FracW);

  logic [CoefW-1:0]        coef_l_q, coef_r_q;
  logic signed [CoefW-1:0] w_c;
  logic                    en;
  logic [StepN:0]          sv;
  div_t                    sd [StepN+1];
  logic                    back_v;
  logic signed [DataW-1:0] back_s;
  logic                    out_v_q, skid_v_q;
  logic signed [DataW-1:0] out_q, skid_q;
  logic                    take;

  always_comb begin
    w_c = cfg_wdata_i;
    if (cfg_wdata_i > One) w_c = One;
    if (cfg_wdata_i < -One) w_c = -One;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_l_q <= CoefW'(One);
      coef_r_q <= CoefW'(One);
    end else if (cfg_we_i) begin
      coef_l_q <= CoefW'(One + w_c);
      coef_r_q <= CoefW'(One - w_c);
    end
  end

  assign en = !skid_v_q;

  mls_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .left_value_i, .centre_value_i, .right_value_i,
    .coef_l_i(coef_l_q), .coef_r_i(coef_r_q),
    .valid_o(sv[0]), .div_o(sd[0])
  );

  for (genvar i = 0; i < StepN; i++) begin : g_div
    mls_div_step u_step (
      .clk_i, .rst_ni, .en_i(en), .valid_i(sv[i]), .div_i(sd[i]),
      .valid_o(sv[i+1]), .div_o(sd[i+1])
    );
  end

  mls_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sv[StepN]), .div_i(sd[StepN]),
    .valid_o(back_v), .slope_o(back_s)
  );

  assign take = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= back_v;
      end
    end else if (en && back_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_v_q ? skid_q : back_s;
    end else if (en && back_v) begin
      skid_q <= back_s;
    end
  end

  assign in_stall_o      = skid_v_q;
  assign out_valid_o     = out_v_q;
  assign limited_slope_o = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid full while output empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && out_v_q && out_stall_i) |=> skid_v_q) else $error("skid lost");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_stall_i) |=> (!skid_v_q && out_v_q)) else $error("skid not drained");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(back_v)) else $error("output without result");

endmodule
